>>> rtl/core/sorted_counted_key_table_defines.svh
// Assertion macros for the sorted counted key table.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
// The macros expect the including module to have clk_i and rst_ni in scope.
`ifndef SORTED_COUNTED_KEY_TABLE_DEFINES_SVH
`define SORTED_COUNTED_KEY_TABLE_DEFINES_SVH

`ifndef SYNTH

// Property checked on every rising edge outside reset.
`define SCKT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising edge outside reset.
`define SCKT_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define SCKT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SCKT_ASSERT(name, prop, msg)
`define SCKT_ASSERT_IMPLY(name, ante, cons, msg)
`define SCKT_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

>>> rtl/core/sckt_pkg.sv
// Package for the sorted counted key table: request and response types,
// command and status codes, cell control and status structs. No dependencies.

package sckt_pkg;

  // Command codes of a request.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Status codes of a response.
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_RANGE     = 2'd3
  } status_e;

  // Top-level control states.
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  localparam int unsigned KeyCoordW = 12;
  localparam int unsigned PosW      = 8;
  localparam int unsigned OccW      = 9;
  localparam int unsigned CountOutW = 24;

  // A key packed so that an unsigned compare is the lexicographic order.
  typedef struct packed {
    logic [KeyCoordW-1:0] x;
    logic [KeyCoordW-1:0] n;
    logic                 folded;
  } key_t;

  typedef struct packed {
    cmd_e                 command;
    logic [KeyCoordW-1:0] key_x;
    logic [KeyCoordW-1:0] key_n;
    logic                 key_folded;
    logic [PosW-1:0]      read_index;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [OccW-1:0]      occupancy;
    logic [PosW-1:0]      position;
    logic [KeyCoordW-1:0] entry_x;
    logic [KeyCoordW-1:0] entry_n;
    logic                 entry_folded;
    logic [CountOutW-1:0] entry_count;
  } rsp_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;   // compare the incoming key against the stored one
    logic ins_new;  // open a gap at the boundary and load the new key
    logic del;      // close the gap at the boundary
    logic wr_cnt;   // rewrite the count of the boundary cell
  } cell_ctrl_t;

  // Flags a cell reports to its neighbour and to the sequencer.
  typedef struct packed {
    logic at;     // this cell sits at or after the insertion point
    logic first;  // this cell is the insertion point
    logic eq;     // stored key equals the compared key
  } cell_stat_t;

endpackage

>>> rtl/core/sckt_cell.sv
// One cell of the sorted key chain: holds a key and its count, compares,
// and shifts to or from its neighbours. Depends on sckt_pkg.

module sckt_cell #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sckt_pkg::cell_ctrl_t    ctrl_i,
  input  logic                    occupied_i,
  input  sckt_pkg::key_t          new_key_i,
  input  logic [COUNT_WIDTH-1:0]  new_count_i,
  input  logic                    prev_at_i,
  input  sckt_pkg::key_t          prev_key_i,
  input  logic [COUNT_WIDTH-1:0]  prev_count_i,
  input  sckt_pkg::key_t          next_key_i,
  input  logic [COUNT_WIDTH-1:0]  next_count_i,
  output sckt_pkg::key_t          key_o,
  output logic [COUNT_WIDTH-1:0]  count_o,
  output sckt_pkg::cell_stat_t    stat_o
);
  import sckt_pkg::*;

  key_t                   key_q, key_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   at_q, at_d;
  logic                   eq_q, eq_d;
  logic                   first;

  // The insertion point is the first cell of the run that is at or after it.
  assign first = at_q & ~prev_at_i;

  // Compare flags are taken when a request is accepted.
  always_comb begin
    at_d = at_q;
    eq_d = eq_q;
    if (ctrl_i.cmp_en) begin
      at_d = ~occupied_i | (new_key_i >= key_q);
      eq_d = occupied_i & (new_key_i == key_q);
    end
  end

  // Stored entry: load, shift from either neighbour or rewrite the count.
  always_comb begin
    key_d   = key_q;
    count_d = count_q;
    if (ctrl_i.ins_new) begin
      if (first) begin
        key_d   = new_key_i;
        count_d = COUNT_WIDTH'(1);
      end else if (at_q) begin
        key_d   = prev_key_i;
        count_d = prev_count_i;
      end
    end else if (ctrl_i.del) begin
      if (at_q) begin
        key_d   = next_key_i;
        count_d = next_count_i;
      end
    end else if (ctrl_i.wr_cnt && first) begin
      count_d = new_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      at_q <= at_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    count_q <= count_d;
  end

  assign key_o        = key_q;
  assign count_o      = count_q;
  assign stat_o.at    = at_q;
  assign stat_o.first = first;
  assign stat_o.eq    = eq_q;

endmodule

>>> rtl/core/sorted_counted_key_table.sv
// Sorted counted key table: a chain of sckt_cell instances and the sequencer
// that drives them. Depends on sckt_pkg and sorted_counted_key_table_defines.svh.
//
//   Channel   Signals                          Carries
//   in        in_valid_i / in_ready_o          req_t: command, key, read index
//   out       out_valid_o / out_ready_i        rsp_t: status, occupancy, entry
//
// For a request, every cell compares the key with its own entry at the accepting
// edge and registers the result; at the next edge the chain shifts or rewrites
// in one step and the response is registered.
// The next request is taken once the response register is empty or being emptied.
// Reset clears the occupancy and the control flags; entry storage needs no clearing pass.
// A stalled output holds its response and blocks further requests.

`include "sorted_counted_key_table_defines.svh"

module sorted_counted_key_table #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sckt_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sckt_pkg::rsp_t out_rsp_o
);
  import sckt_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TotW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RdW  = (TotW > PosW) ? TotW : PosW;

  state_e                 state_q, state_d;
  logic [TotW-1:0]        total_q, total_d;
  logic                   out_valid_q, out_valid_d;
  rsp_t                   rsp_q, rsp_d;
  cmd_e                   cmd_q;
  key_t                   key_q;
  logic [PosW-1:0]        idx_q;

  logic                   in_accept;
  key_t                   in_key;
  cell_ctrl_t             ctrl;
  logic [COUNT_WIDTH-1:0] wr_count;

  key_t                   cell_key   [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] cell_count [TABLE_DEPTH];
  cell_stat_t             cell_stat  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occupied;
  logic [TABLE_DEPTH-1:0] first_vec;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] rd_vec;
  logic [TABLE_DEPTH-1:0] sel_vec;

  logic [IdxW-1:0]        sel_pos;
  key_t                   sel_key;
  logic [COUNT_WIDTH-1:0] sel_count;
  logic                   hit;
  logic                   any_first;
  logic [TotW-1:0]        ins_pos;
  logic                   rd_in_range;
  logic [RdW-1:0]         rd_ext;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_dec;

  assign in_accept  = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) & (~out_valid_q | out_ready_i);
  assign in_key     = '{x: in_req_i.key_x, n: in_req_i.key_n, folded: in_req_i.key_folded};
  assign rd_ext     = RdW'(idx_q);

  // Chain of cells; the ends tie their missing neighbour's key and count to themselves.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    key_t                   prev_key;
    logic [COUNT_WIDTH-1:0] prev_count;
    logic                   prev_at;
    key_t                   next_key;
    logic [COUNT_WIDTH-1:0] next_count;

    if (i == 0) begin : g_head
      assign prev_key   = cell_key[i];
      assign prev_count = cell_count[i];
      assign prev_at    = 1'b0;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_count = cell_count[i-1];
      assign prev_at    = cell_stat[i-1].at;
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_key   = cell_key[i];
      assign next_count = cell_count[i];
    end else begin : g_mid
      assign next_key   = cell_key[i+1];
      assign next_count = cell_count[i+1];
    end

    assign occupied[i]  = TotW'(i) < total_q;
    assign first_vec[i] = cell_stat[i].first;
    assign hit_vec[i]   = cell_stat[i].first & cell_stat[i].eq;
    assign rd_vec[i]    = rd_ext == RdW'(i);

    sckt_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied[i]),
      .new_key_i   (ctrl.cmp_en ? in_key : key_q),
      .new_count_i (wr_count),
      .prev_at_i   (prev_at),
      .prev_key_i  (prev_key),
      .prev_count_i(prev_count),
      .next_key_i  (next_key),
      .next_count_i(next_count),
      .key_o       (cell_key[i]),
      .count_o     (cell_count[i]),
      .stat_o      (cell_stat[i])
    );
  end

  // One-hot selection of the touched or read entry.
  assign sel_vec = (cmd_q == CMD_READ) ? rd_vec : first_vec;

  always_comb begin
    sel_pos   = '0;
    sel_key   = '0;
    sel_count = '0;
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      sel_pos   = sel_pos   | (sel_vec[i] ? IdxW'(i) : '0);
      sel_key   = sel_key   | (sel_vec[i] ? cell_key[i] : '0);
      sel_count = sel_count | (sel_vec[i] ? cell_count[i] : '0);
    end
  end

  assign hit         = |hit_vec;
  assign any_first   = |first_vec;
  assign ins_pos     = any_first ? TotW'(sel_pos) : total_q;
  assign rd_in_range = rd_ext < RdW'(total_q);
  assign cnt_inc     = (&sel_count) ? sel_count : sel_count + COUNT_WIDTH'(1);
  assign cnt_dec     = sel_count - COUNT_WIDTH'(1);

  // Sequencer: next state, cell control and the response.
  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q;
    rsp_d        = rsp_q;
    ctrl         = '0;
    ctrl.cmp_en  = in_accept;
    wr_count     = cnt_inc;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        rsp_d       = '0;
        rsp_d.status = STS_OK;
        unique case (cmd_q)
          CMD_INSERT: begin
            rsp_d.position     = PosW'(ins_pos);
            rsp_d.entry_x      = key_q.x;
            rsp_d.entry_n      = key_q.n;
            rsp_d.entry_folded = key_q.folded;
            if (hit) begin
              ctrl.wr_cnt       = 1'b1;
              wr_count          = cnt_inc;
              rsp_d.entry_count = CountOutW'(cnt_inc);
            end else if (total_q == TotW'(TABLE_DEPTH)) begin
              rsp_d.status = STS_FULL;
            end else begin
              ctrl.ins_new      = 1'b1;
              total_d           = total_q + TotW'(1);
              rsp_d.entry_count = CountOutW'(1);
            end
          end
          CMD_REMOVE: begin
            rsp_d.entry_x      = key_q.x;
            rsp_d.entry_n      = key_q.n;
            rsp_d.entry_folded = key_q.folded;
            if (!hit) begin
              rsp_d.status = STS_NOT_FOUND;
            end else begin
              rsp_d.position = PosW'(ins_pos);
              if (sel_count > COUNT_WIDTH'(1)) begin
                ctrl.wr_cnt       = 1'b1;
                wr_count          = cnt_dec;
                rsp_d.entry_count = CountOutW'(cnt_dec);
              end else begin
                ctrl.del = 1'b1;
                total_d  = total_q - TotW'(1);
              end
            end
          end
          CMD_READ: begin
            rsp_d.position = idx_q;
            if (rd_in_range) begin
              rsp_d.entry_x      = sel_key.x;
              rsp_d.entry_n      = sel_key.n;
              rsp_d.entry_folded = sel_key.folded;
              rsp_d.entry_count  = CountOutW'(sel_count);
            end else begin
              rsp_d.status = STS_RANGE;
            end
          end
          default: begin
            rsp_d.status = STS_OK;
          end
        endcase
        rsp_d.occupancy = OccW'(total_d);
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (in_accept) begin
      cmd_q <= in_req_i.command;
      key_q <= in_key;
      idx_q <= in_req_i.read_index;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // The response register is always free when a result is written.
  `SCKT_ASSERT_IMPLY(a_slot_free, state_q == ST_UPDATE, !out_valid_q, "response slot busy")
  // Occupancy never exceeds the depth.
  `SCKT_ASSERT(a_total_bound, total_q <= TotW'(TABLE_DEPTH), "occupancy beyond depth")
  // At most one cell claims the insertion point.
  `SCKT_ASSERT_IMPLY(a_one_first, state_q == ST_UPDATE, $onehot0(first_vec), "several boundaries")
  // An accepted request is always worked off in the next cycle.
  `SCKT_ASSERT_NEXT(a_accept_upd, in_accept, state_q == ST_UPDATE, "request not processed")
  // Occupancy only moves when a request completes.
  `SCKT_ASSERT_NEXT(a_total_hold, state_q == ST_IDLE, $stable(total_q), "occupancy moved idle")

endmodule

>>> bench/sorted_counted_key_table_checker.sv
// Checker for the sorted counted key table: watches both channels, keeps its own
// copy of the sorted table, predicts each response and compares it field by field.
// Depends on sckt_pkg only.

module sorted_counted_key_table_checker #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  sckt_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  sckt_pkg::rsp_t out_rsp_i,
  output int             error_count_o,
  output int             pending_count_o
);
  import sckt_pkg::*;

  // Shadow copy of the table, kept in descending key order.
  key_t                 key_slots   [TABLE_DEPTH];
  logic [CountOutW-1:0] count_slots [TABLE_DEPTH];
  int                   live_total;

  // Responses still owed by the block, oldest first.
  rsp_t awaited_rsps [$];
  rsp_t oldest;

  // Applies one request to the shadow table and returns the response it must cause.
  function automatic rsp_t table_response(req_t r);
    key_t k;
    rsp_t o;
    int   i;
    int   j;
    k = '{x: r.key_x, n: r.key_n, folded: r.key_folded};
    o = '0;
    i = 0;
    case (r.command)
      CMD_INSERT: begin
        // The first entry not greater than the key is where it belongs.
        while (i < live_total && k < key_slots[i]) i++;
        o.position     = PosW'(i);
        o.entry_x      = k.x;
        o.entry_n      = k.n;
        o.entry_folded = k.folded;
        if (i < live_total && key_slots[i] == k) begin
          // The count saturates at its all-ones value.
          if (count_slots[i] != '1) count_slots[i] = count_slots[i] + CountOutW'(1);
          o.status      = STS_OK;
          o.entry_count = count_slots[i];
        end else if (live_total >= int'(TABLE_DEPTH)) begin
          o.status      = STS_FULL;
          o.entry_count = '0;
        end else begin
          for (j = live_total; j > i; j--) begin
            key_slots[j]   = key_slots[j-1];
            count_slots[j] = count_slots[j-1];
          end
          key_slots[i]   = k;
          count_slots[i] = CountOutW'(1);
          live_total++;
          o.status      = STS_OK;
          o.entry_count = CountOutW'(1);
        end
      end
      CMD_REMOVE: begin
        while (i < live_total && key_slots[i] != k) i++;
        o.entry_x      = k.x;
        o.entry_n      = k.n;
        o.entry_folded = k.folded;
        if (i >= live_total) begin
          o.status = STS_NOT_FOUND;
        end else if (count_slots[i] > CountOutW'(1)) begin
          count_slots[i] = count_slots[i] - CountOutW'(1);
          o.status      = STS_OK;
          o.position    = PosW'(i);
          o.entry_count = count_slots[i];
        end else begin
          // Last occurrence: the entry goes and the later ones close the gap.
          for (j = i; j < live_total - 1; j++) begin
            key_slots[j]   = key_slots[j+1];
            count_slots[j] = count_slots[j+1];
          end
          live_total--;
          o.status   = STS_OK;
          o.position = PosW'(i);
        end
      end
      CMD_READ: begin
        o.position = r.read_index;
        if (int'(r.read_index) >= live_total) begin
          o.status = STS_RANGE;
        end else begin
          o.status       = STS_OK;
          o.entry_x      = key_slots[r.read_index].x;
          o.entry_n      = key_slots[r.read_index].n;
          o.entry_folded = key_slots[r.read_index].folded;
          o.entry_count  = count_slots[r.read_index];
        end
      end
      default: begin
        o.status = STS_OK;
      end
    endcase
    o.occupancy = OccW'(live_total);
    return o;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count_o++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Responses are checked before the request of the same edge is predicted,
  // so a response can never be matched against its own request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_total      = 0;
      error_count_o   = 0;
      pending_count_o = 0;
      awaited_rsps.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_rsps.size() == 0) begin
          error_count_o++;
          $display("%0t: response with none expected, expected nothing, actual %h",
                   $time, out_rsp_i);
        end else begin
          oldest = awaited_rsps.pop_front();
          check_field("status", 32'(oldest.status), 32'(out_rsp_i.status));
          check_field("occupancy", 32'(oldest.occupancy), 32'(out_rsp_i.occupancy));
          check_field("position", 32'(oldest.position), 32'(out_rsp_i.position));
          check_field("entry_x", 32'(oldest.entry_x), 32'(out_rsp_i.entry_x));
          check_field("entry_n", 32'(oldest.entry_n), 32'(out_rsp_i.entry_n));
          check_field("entry_folded", 32'(oldest.entry_folded),
                      32'(out_rsp_i.entry_folded));
          check_field("entry_count", 32'(oldest.entry_count), 32'(out_rsp_i.entry_count));
        end
      end
      if (in_valid_i && in_ready_i) awaited_rsps.push_back(table_response(in_req_i));
      pending_count_o = awaited_rsps.size();
    end
  end

endmodule

>>> bench/sorted_counted_key_table_test.sv
// Top of the sorted counted key table bench: clock, reset, request stimulus and
// response back-pressure, with the checker beside the block giving the verdict.
// Depends on sckt_pkg, sorted_counted_key_table and sorted_counted_key_table_checker.

module sorted_counted_key_table_test;
  import sckt_pkg::*;

  localparam int unsigned Depth     = 256;
  localparam int          QuietMax  = 5000;
  localparam int          HotKeys   = 24;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int error_count;
  int pending_count;

  // Request source state.
  int   burst_left = 0;
  key_t hot_keys  [HotKeys];
  key_t fill_keys [$];

  // Response sink state.
  int ready_mode = 0;
  int ready_span = 0;

  int quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sorted_counted_key_table #(
    .TABLE_DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_req_i   (req),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_rsp_o  (rsp)
  );

  sorted_counted_key_table_checker #(
    .TABLE_DEPTH(Depth)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_valid),
    .in_ready_i     (req_ready),
    .in_req_i       (req),
    .out_valid_i    (rsp_valid),
    .out_ready_i    (rsp_ready),
    .out_rsp_i      (rsp),
    .error_count_o  (error_count),
    .pending_count_o(pending_count)
  );

  function automatic key_t random_key();
    return key_t'(25'($urandom));
  endfunction

  // Mostly keys from the small pool, so that repeats and removes find their match.
  function automatic key_t pool_or_fresh_key();
    if ($urandom_range(0, 9) < 7) return hot_keys[$urandom_range(0, HotKeys - 1)];
    return random_key();
  endfunction

  // Sends one request. The source works in bursts, usually dropping valid between them.
  // Called and left at a falling edge.
  task automatic issue(input cmd_e cmd, input key_t k, input logic [PosW-1:0] idx);
    req_t r;
    int   gap;
    r.command    = cmd;
    r.key_x      = k.x;
    r.key_n      = k.n;
    r.key_folded = k.folded;
    r.read_index = idx;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk_i);
    while (!req_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // The sink switches between always ready, half stalled and mostly stalled.
  always @(negedge clk_i) begin
    if (ready_span == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_span = $urandom_range(20, 120);
    end
    ready_span--;
    case (ready_mode)
      0:       rsp_ready <= 1'b1;
      1:       rsp_ready <= ($urandom_range(0, 1) == 1);
      default: rsp_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: a long run of edges without any handshake ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietMax) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    key_t top_key;
    key_t bottom_key;
    key_t k;
    int   pick;
    int   sel;

    top_key    = '{x: '1, n: '1, folded: 1'b1};
    bottom_key = '0;
    // Pairs in the pool differ only in the folded flag.
    for (int i = 0; i < HotKeys; i += 2) begin
      hot_keys[i]          = random_key();
      hot_keys[i+1]        = hot_keys[i];
      hot_keys[i+1].folded = ~hot_keys[i].folded;
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty table, extreme keys, neighbours, repeats and deletion.
    issue(CMD_READ, random_key(), '0);
    issue(CMD_REMOVE, random_key(), 8'($urandom));
    issue(CMD_NOP, random_key(), 8'($urandom));
    issue(CMD_INSERT, top_key, 8'($urandom));
    issue(CMD_INSERT, bottom_key, 8'($urandom));
    issue(CMD_INSERT, top_key, 8'($urandom));
    issue(CMD_INSERT, '{x: '1, n: '1, folded: 1'b0}, 8'($urandom));
    issue(CMD_INSERT, '{x: '1, n: 12'hFFE, folded: 1'b1}, 8'($urandom));
    issue(CMD_INSERT, '{x: 12'h800, n: '0, folded: 1'b1}, 8'($urandom));
    for (int i = 0; i < 6; i++) issue(CMD_READ, random_key(), 8'(i));
    issue(CMD_READ, random_key(), '1);
    issue(CMD_REMOVE, top_key, 8'($urandom));
    issue(CMD_REMOVE, top_key, 8'($urandom));
    issue(CMD_REMOVE, top_key, 8'($urandom));
    issue(CMD_REMOVE, bottom_key, 8'($urandom));
    issue(CMD_NOP, random_key(), '1);
    issue(CMD_READ, random_key(), '0);

    // Mixed traffic on a small key pool.
    for (int i = 0; i < 150; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) issue(CMD_INSERT, pool_or_fresh_key(), 8'($urandom));
      else if (pick < 14) issue(CMD_REMOVE, pool_or_fresh_key(), 8'($urandom));
      else if (pick < 19)
        issue(CMD_READ, random_key(),
              ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 15)) : 8'($urandom));
      else issue(CMD_NOP, random_key(), 8'($urandom));
    end

    // Growth to a full table: each new key has its own sample size, so all differ.
    for (int i = 0; i < 260; i++) begin
      k   = random_key();
      k.n = 12'(i);
      fill_keys.push_back(k);
      issue(CMD_INSERT, k, 8'($urandom));
      if ($urandom_range(0, 5) == 0) issue(CMD_READ, random_key(), 8'($urandom));
    end

    // Work at full occupancy: refused keys, repeats, reads at the far end and
    // a slot freed and taken again.
    for (int i = 0; i < 40; i++) begin
      sel = $urandom_range(0, 4);
      case (sel)
        0: issue(CMD_INSERT, random_key(), 8'($urandom));
        1: issue(CMD_INSERT, fill_keys[$urandom_range(0, fill_keys.size() - 1)],
                 8'($urandom));
        2: issue(CMD_READ, random_key(), 8'($urandom_range(240, 255)));
        3: begin
          pick = $urandom_range(0, fill_keys.size() - 1);
          issue(CMD_REMOVE, fill_keys[pick], 8'($urandom));
          fill_keys.delete(pick);
          issue(CMD_INSERT, random_key(), 8'($urandom));
        end
        default: issue(CMD_INSERT, hot_keys[$urandom_range(0, HotKeys - 1)], 8'($urandom));
      endcase
    end

    // Drain in random order, with reads and removes of absent keys mixed in.
    for (int i = 0; i < 130 && fill_keys.size() > 0; i++) begin
      pick = $urandom_range(0, fill_keys.size() - 1);
      issue(CMD_REMOVE, fill_keys[pick], 8'($urandom));
      fill_keys.delete(pick);
      if ($urandom_range(0, 3) == 0) issue(CMD_READ, random_key(), 8'($urandom));
      if ($urandom_range(0, 7) == 0) issue(CMD_REMOVE, random_key(), 8'($urandom));
    end

    // Let every owed response arrive, then watch a few more edges for strays.
    req_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
